@@ sv/gsi_pkg.sv @@
`default_nettype none

package gsi_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned IMP_W     = 15;
    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned QUO_W     = 16;
    localparam int unsigned FRAC_W    = 15;

    localparam logic [DATA_W-1:0] ONE_Q15  = 16'd32768;
    localparam logic [DATA_W-1:0] HALF_Q15 = 16'd16384;

    typedef logic [DATA_W-1:0] q15_t;

    // handshake of the shared divider
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic running;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/gini_split_impurity.sv @@
`default_nettype none

// Channel   Direction  Ports                                     Transfer
// input     in         start, busy, truth_value,                 start & !busy
//                      prediction_value, last_item
// result    out        result_valid, impurity, item_count,       result_valid, one cycle
//                      overflowed
//
// A pair without last_item is summed in the cycle it is accepted; busy stays low.
// A pair with last_item holds busy for up to three 16-step divisions (left p, right p,
// weighted mean) on one shared divider and the products on one shared multiplier;
// a side with no pairs skips its division. The result strobe comes in the first cycle
// with busy low, and a new pair may be taken then.
// rst_n clears sums, counts and the sequencer at once. The receiver cannot stall.

module gini_split_impurity #(
    parameter int unsigned MAX_ITEMS = 65536
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [gsi_pkg::DATA_W-1:0]     truth_value,
    input  wire logic [gsi_pkg::DATA_W-1:0]     prediction_value,
    input  wire logic                           last_item,
    output logic                                result_valid,
    output logic [gsi_pkg::IMP_W-1:0]           impurity,
    output logic [gsi_pkg::COUNT_W-1:0]         item_count,
    output logic                                overflowed
);

    localparam int unsigned CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SUM_W   = CNT_W + gsi_pkg::FRAC_W;
    localparam int unsigned MUL_A_W = (CNT_W > gsi_pkg::DATA_W) ? CNT_W : gsi_pkg::DATA_W;
    localparam int unsigned PROD_W  = MUL_A_W + gsi_pkg::DATA_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_DWAIT = 3'd2;
    localparam logic [2:0] S_MULG  = 3'd3;
    localparam logic [2:0] S_MULW  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_FWAIT = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [SUM_W-1:0]            sum_l_reg, sum_r_reg;
    logic [CNT_W-1:0]            cnt_l_reg, cnt_r_reg;
    logic                        ovf_reg;
    logic                        side_reg;
    logic [gsi_pkg::QUO_W-1:0]   p_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [SUM_W-1:0]            acc_reg;
    logic                        valid_reg;
    logic [gsi_pkg::IMP_W-1:0]   imp_reg;
    logic [gsi_pkg::COUNT_W-1:0] count_reg;
    logic                        ovf_out_reg;

    logic                        accept;
    logic [gsi_pkg::DATA_W-1:0]  truth_sat;
    logic [CNT_W:0]              total_wide;
    logic [CNT_W-1:0]            total;
    logic                        full;
    logic [SUM_W-1:0]            side_sum;
    logic [CNT_W-1:0]            side_cnt;
    logic [gsi_pkg::IMP_W-1:0]   gini;
    logic [MUL_A_W-1:0]          mul_a;
    logic [gsi_pkg::DATA_W-1:0]  mul_b;
    logic [PROD_W-1:0]           mul_p;
    gsi_pkg::div_req_t           div_req;
    gsi_pkg::div_rsp_t           div_rsp;
    logic [SUM_W-1:0]            div_dividend;
    logic [CNT_W-1:0]            div_divisor;
    logic [gsi_pkg::QUO_W-1:0]   div_quo;
    logic                        emit;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign truth_sat  = (truth_value > gsi_pkg::ONE_Q15) ? gsi_pkg::ONE_Q15 : truth_value;
    assign total_wide = {1'b0, cnt_l_reg} + {1'b0, cnt_r_reg};
    assign total      = total_wide[CNT_W-1:0];
    assign full       = (total_wide >= (CNT_W + 1)'(MAX_ITEMS));

    assign side_sum = side_reg ? sum_r_reg : sum_l_reg;
    assign side_cnt = side_reg ? cnt_r_reg : cnt_l_reg;

    // gini = 2 p (1 - p) >> 15, taken from the registered product
    assign gini = prod_reg[28:14];

    assign mul_a = (state_reg == S_MULG) ? MUL_A_W'(p_reg) : MUL_A_W'(side_cnt);
    assign mul_b = (state_reg == S_MULG) ? 16'(17'(gsi_pkg::ONE_Q15) - 17'(p_reg))
                                         : gsi_pkg::DATA_W'(gini);
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_req.start = ((state_reg == S_DIV) && (side_cnt != '0))
                        || ((state_reg == S_FIN) && (total != '0));
    assign div_dividend  = (state_reg == S_FIN) ? acc_reg : side_sum;
    assign div_divisor   = (state_reg == S_FIN) ? total : side_cnt;

    gsi_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_quo)
    );

    assign emit = ((state_reg == S_FWAIT) && div_rsp.done)
               || ((state_reg == S_FIN) && (total == '0));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && last_item)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = (side_cnt != '0) ? S_DWAIT : S_MULG;
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_MULG;
                end
            end
            S_MULG:
            begin
                state_next = S_MULW;
            end
            S_MULW:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = side_reg ? S_FIN : S_DIV;
            end
            S_FIN:
            begin
                state_next = (total != '0) ? S_FWAIT : S_IDLE;
            end
            S_FWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_l_reg <= '0;
            sum_r_reg <= '0;
            cnt_l_reg <= '0;
            cnt_r_reg <= '0;
            ovf_reg   <= 1'b0;
            side_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= emit;
            if (accept)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else if (prediction_value > gsi_pkg::HALF_Q15)
                begin
                    sum_l_reg <= sum_l_reg + SUM_W'(truth_sat);
                    cnt_l_reg <= cnt_l_reg + 1'b1;
                end
                else
                begin
                    sum_r_reg <= sum_r_reg + SUM_W'(truth_sat);
                    cnt_r_reg <= cnt_r_reg + 1'b1;
                end
                side_reg <= 1'b0;
            end
            else if (state_reg == S_ACC)
            begin
                side_reg <= 1'b1;
            end
            // drop the set once its result is out
            if (emit)
            begin
                sum_l_reg <= '0;
                sum_r_reg <= '0;
                cnt_l_reg <= '0;
                cnt_r_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == S_ACC)
        begin
            acc_reg <= acc_reg + prod_reg[SUM_W-1:0];
        end
        if (state_reg == S_DIV)
        begin
            p_reg <= '0;
        end
        else if ((state_reg == S_DWAIT) && div_rsp.done)
        begin
            p_reg <= div_quo;
        end
        if ((state_reg == S_MULG) || (state_reg == S_MULW))
        begin
            prod_reg <= mul_p;
        end
        if (emit)
        begin
            imp_reg     <= (state_reg == S_FWAIT) ? div_quo[gsi_pkg::IMP_W-1:0] : '0;
            count_reg   <= gsi_pkg::COUNT_W'(total);
            ovf_out_reg <= ovf_reg;
        end
    end

    assign result_valid = valid_reg;
    assign impurity     = imp_reg;
    assign item_count   = count_reg;
    assign overflowed   = ovf_out_reg;

    a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_item) |=> busy)
        else $error("closing transaction did not start the computation");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_wide <= (CNT_W + 1)'(MAX_ITEMS))
        else $error("pair count beyond capacity");

endmodule

`default_nettype wire

@@ sv/gsi_div.sv @@
`default_nettype none

module gsi_div #(
    parameter int unsigned DVD_W = 40,
    parameter int unsigned DVS_W = 25
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire gsi_pkg::div_req_t           req,
    input  wire logic [DVD_W-1:0]            dividend,
    input  wire logic [DVS_W-1:0]            divisor,
    output gsi_pkg::div_rsp_t                rsp,
    output logic [gsi_pkg::QUO_W-1:0]        quotient
);

    localparam int unsigned STEP_W = $clog2(gsi_pkg::QUO_W);

    logic [DVD_W-1:0]          rem_reg;
    logic [DVD_W-1:0]          dsr_reg;
    logic [gsi_pkg::QUO_W-1:0] quo_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic                      fits;

    // quotient is known to fit QUO_W bits, so the divisor starts aligned to its top bit
    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(gsi_pkg::QUO_W - 1);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= dividend;
            dsr_reg <= DVD_W'(divisor) << (gsi_pkg::QUO_W - 1);
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            quo_reg <= {quo_reg[gsi_pkg::QUO_W-2:0], fits};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.running = run_reg;
    assign quotient    = quo_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!run_reg && $past(run_reg)))
        else $error("divider done without a finished run");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !run_reg)
        else $error("divider started while running");

endmodule

`default_nettype wire
